>>> sv/rgb_color_temperature_lux_top_assert.svh
// assertion macros for the color temperature / lux block
`ifndef RGB_COLOR_TEMPERATURE_LUX_TOP_ASSERT_SVH
`define RGB_COLOR_TEMPERATURE_LUX_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked property, switched off while reset is high
`define RGBCCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked property that also holds across reset
`define RGBCCT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RGBCCT_ASSERT(lbl, prop, msg)
`define RGBCCT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/rgbcct_pkg.sv
// shared types, constants and helpers for the color temperature / lux block
`timescale 1ns / 1ps
package rgbcct_pkg;

   localparam int CH_W    = 16;
   localparam int COEF_W  = 18;
   localparam int PROD_W  = 35;
   localparam int XYZ_W   = 38;
   localparam int MAG_W   = 37;
   localparam int FRAC_W  = 20;
   localparam int LUX_SH  = 16;
   localparam int Q1_W    = MAG_W + FRAC_W;
   localparam int NUM_W   = Q1_W + 1;
   localparam int Q2_W    = NUM_W + FRAC_W;
   localparam int N_MAG_W = 25;
   localparam int N_W     = N_MAG_W + 1;
   localparam int NSQ_W   = 49;
   localparam int N2_W    = 29;
   localparam int N3P_W   = 56;
   localparam int N3_W    = 34;
   localparam int LIN_W   = 60;
   localparam int LINT_W  = 40;
   localparam int CCT_W   = 44;

   localparam logic signed [COEF_W-1:0] MAT_COEF [3][3] = '{
      '{-18'sd9360,  18'sd101531, -18'sd62679},
      '{-18'sd21277, 18'sd103440, -18'sd47966},
      '{-18'sd44697, 18'sd50511,   18'sd36918}
   };

   localparam logic signed [NUM_W:0] X0_Q20 = (NUM_W+1)'(348127);
   localparam logic signed [NUM_W:0] Y0_Q20 = (NUM_W+1)'(194825);
   localparam logic [N_MAG_W-1:0] N_LIMIT = 25'd16777216;

   localparam logic signed [33:0]      K_LIN   = 34'sd7154748621;
   localparam logic signed [CCT_W-1:0] CCT_OFS = 44'sd5788485550;
   localparam logic signed [10:0]      C_CUBE  = 11'sd449;
   localparam logic signed [12:0]      C_SQ    = 13'sd3525;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DEGEN = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic            degen;
      logic            lux_sat;
      logic [CH_W-1:0] lux;
   } side_type;

   typedef struct packed {
      logic     neg;
      side_type side;
   } div_side_type;

   typedef struct packed {
      logic [CH_W-1:0] value;
      logic            sat;
   } sat16_type;

   // shift right, rounding toward zero
   function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic [63:0] m;
      m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
      m = m >> sh;
      return v[63] ? $signed(64'd0 - m) : $signed(m);
   endfunction

   function automatic sat16_type sat16(input logic signed [63:0] v);
      sat16_type r;
      if (v < 0) begin
         r.value = '0;
         r.sat   = 1'b1;
      end else if (v > 64'sd65535) begin
         r.value = '1;
         r.sat   = 1'b1;
      end else begin
         r.value = v[CH_W-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> sv/rgbcct_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rgbcct_div #(
   parameter int DVD_W  = 57,
   parameter int DVS_W  = 37,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [DVD_W-1:0]  quotient,
   output logic [SIDE_W-1:0] side_out
);

   // dq holds the dividend bits still to come on top and the quotient below
   logic              vld_ff  [DVD_W];
   logic [DVD_W-1:0]  dq_ff   [DVD_W];
   logic [SIDE_W-1:0] side_ff [DVD_W];
   logic [DVS_W-1:0]  rem_ff  [DVD_W-1];
   logic [DVS_W-1:0]  dvs_ff  [DVD_W-1];

   for (genvar k = 0; k < DVD_W; k++) begin : g_step
      logic              vld_prev;
      logic [DVD_W-1:0]  dq_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DVS_W-1:0]  rem_prev;
      logic [DVS_W-1:0]  dvs_prev;
      logic [DVS_W:0]    trial;
      logic [DVS_W+1:0]  diff;
      logic              fits;
      logic [DVS_W-1:0]  rem_in;
      logic [DVD_W-1:0]  dq_in;

      if (k == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign dq_prev   = dividend;
         assign side_prev = side_in;
         assign rem_prev  = '0;
         assign dvs_prev  = divisor;
      end else begin : g_body
         assign vld_prev  = vld_ff[k-1];
         assign dq_prev   = dq_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign dvs_prev  = dvs_ff[k-1];
      end

      always_comb begin
         trial  = {rem_prev, dq_prev[DVD_W-1]};
         diff   = {1'b0, trial} - {2'b00, dvs_prev};
         fits   = !diff[DVS_W+1];
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dq_in  = {dq_prev[DVD_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dq_ff[k]   <= dq_in;
            side_ff[k] <= side_prev;
         end
      end

      if (k < DVD_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
               dvs_ff[k] <= dvs_prev;
            end
         end
      end
   end

   assign out_valid = vld_ff[DVD_W-1];
   assign quotient  = dq_ff[DVD_W-1];
   assign side_out  = side_ff[DVD_W-1];

endmodule

>>> sv/rgbcct_mat.sv
// rgb to xyz matrix, sum and lux, three register stages
`timescale 1ns / 1ps
module rgbcct_mat
   import rgbcct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [CH_W-1:0]         red,
   input  logic [CH_W-1:0]         green,
   input  logic [CH_W-1:0]         blue,
   output logic                    out_valid,
   output logic signed [XYZ_W-1:0] x_val,
   output logic signed [XYZ_W-1:0] y_val,
   output logic signed [XYZ_W-1:0] s_val,
   output logic [CH_W-1:0]         lux,
   output logic                    lux_sat
);

   logic [CH_W-1:0]          ch [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [XYZ_W-1:0]  xyz_in [3];
   logic signed [XYZ_W-1:0]  xyz_ff [3];
   logic signed [XYZ_W-1:0]  x_ff, y_ff, s_ff, s_in;
   logic [CH_W-1:0]          lux_ff;
   logic                     lux_sat_ff;
   logic                     v_ff [3];
   logic signed [63:0]       lux_t;
   sat16_type                lux_s;

   always_comb begin
      ch[0] = red;
      ch[1] = green;
      ch[2] = blue;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = MAT_COEF[i][j] * $signed({1'b0, ch[j]});
         end
      end
      for (int i = 0; i < 3; i++) begin
         xyz_in[i] = XYZ_W'(prod_ff[i][0]) + XYZ_W'(prod_ff[i][1])
                   + XYZ_W'(prod_ff[i][2]);
      end
      s_in  = xyz_ff[0] + xyz_ff[1] + xyz_ff[2];
      lux_t = trunc_shift(64'(xyz_ff[1]), LUX_SH);
      lux_s = sat16(lux_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= in_valid;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= prod_in;
         xyz_ff     <= xyz_in;
         x_ff       <= xyz_ff[0];
         y_ff       <= xyz_ff[1];
         s_ff       <= s_in;
         lux_ff     <= lux_s.value;
         lux_sat_ff <= lux_s.sat;
      end
   end

   assign out_valid = v_ff[2];
   assign x_val     = x_ff;
   assign y_val     = y_ff;
   assign s_val     = s_ff;
   assign lux       = lux_ff;
   assign lux_sat   = lux_sat_ff;

endmodule

>>> sv/rgbcct_cubic.sv
// cubic polynomial in n to kelvin, four register stages
`timescale 1ns / 1ps
module rgbcct_cubic
   import rgbcct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [N_W-1:0] n,
   input  side_type              side_in,
   output logic                  out_valid,
   output logic [CH_W-1:0]       kelvin,
   output logic                  kelvin_sat,
   output side_type              side_out
);

   logic                      v_ff [4];
   side_type                  side_ff [4];
   logic signed [2*N_W-1:0]   sq_full;
   logic [NSQ_W-1:0]          nsq_in, nsq_ff;
   logic signed [LIN_W-1:0]   lin_in, lin_ff;
   logic signed [N_W-1:0]     n1_ff;
   logic [N2_W-1:0]           n2_in, n2_ff;
   logic signed [N3P_W-1:0]   n3p_in, n3p_ff;
   logic signed [LINT_W-1:0]  lint_in, lint_ff;
   logic signed [N3_W-1:0]    n3;
   logic signed [CCT_W-1:0]   cct_in, cct_ff;
   logic signed [63:0]        t_lin, t_n3, t_k;
   sat16_type                 k_s;
   logic [CH_W-1:0]           kelvin_ff;
   logic                      ksat_ff;

   always_comb begin
      sq_full = n * n;
      nsq_in  = sq_full[NSQ_W-1:0];
      lin_in  = K_LIN * n;
      // n squared is never negative: plain shift
      n2_in   = nsq_ff[NSQ_W-1:FRAC_W];
      n3p_in  = $signed({1'b0, n2_in}) * n1_ff;
      t_lin   = trunc_shift(64'(lin_ff), FRAC_W);
      lint_in = t_lin[LINT_W-1:0];
      t_n3    = trunc_shift(64'(n3p_ff), FRAC_W);
      n3      = t_n3[N3_W-1:0];
      cct_in  = C_CUBE * n3 + C_SQ * $signed({1'b0, n2_ff}) + lint_ff + CCT_OFS;
      t_k     = trunc_shift(64'(cct_ff), FRAC_W);
      k_s     = sat16(t_k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         nsq_ff    <= nsq_in;
         lin_ff    <= lin_in;
         n1_ff     <= n;
         n2_ff     <= n2_in;
         n3p_ff    <= n3p_in;
         lint_ff   <= lint_in;
         cct_ff    <= cct_in;
         kelvin_ff <= k_s.value;
         ksat_ff   <= k_s.sat;
      end
   end

   assign out_valid  = v_ff[3];
   assign kelvin     = kelvin_ff;
   assign kelvin_sat = ksat_ff;
   assign side_out   = side_ff[3];

endmodule

>>> sv/rgb_color_temperature_lux_top.sv
// top level: rgb sample in, color temperature, lux and status out
// Takes one 16-bit red, green, blue sample per beat on the req_ channel and
// returns one beat on the rsp_ channel: kelvin (McCamy cubic on the xy
// chromaticity), illuminance (the Y value) and status (ok, degenerate, saturated).
// A beat is moved at a rising edge where valid is high and stall is low.
// From accepted req_ beat to rsp_valid a sample passes through 3 matrix
// stages, 57 stages for the x and y division, 1 subtract stage, 78 stages
// for the n division, 1 clamp stage, 4 polynomial stages and the output
// register; the two long dividers take one quotient bit per stage.
// Throughput is one sample per cycle while req_stall is low.
// The whole pipeline moves as one: while a result waits in the output
// register under rsp_stall, req_stall is raised and every stage holds,
// so nothing is dropped or repeated. Bubbles travel with valid bits.
// Synchronous reset clears every valid bit; data registers keep junk that
// is never shown. No configuration and no state carries from one sample on.
`timescale 1ns / 1ps
`include "rgb_color_temperature_lux_top_assert.svh"
module rgb_color_temperature_lux_top
   import rgbcct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [CH_W-1:0] req_red,
   input  logic [CH_W-1:0] req_green,
   input  logic [CH_W-1:0] req_blue,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CH_W-1:0] rsp_kelvin,
   output logic [CH_W-1:0] rsp_illuminance,
   output logic [1:0]      rsp_status
);

   logic advance;

   logic                    m_valid;
   logic signed [XYZ_W-1:0] m_x, m_y, m_s;
   logic [CH_W-1:0]         m_lux;
   logic                    m_lux_sat;

   logic signed [XYZ_W-1:0] x_abs, y_abs, s_abs;
   div_side_type            xs_in, xs_out;
   logic                    ys_in, ys_out;
   logic                    dx_valid, dy_valid;
   logic [Q1_W-1:0]         qx, qy;

   logic signed [NUM_W-1:0] xc, yc;
   logic signed [NUM_W:0]   num, den, num_abs, den_abs;
   side_type                p_side_in;
   logic                    p_v_ff;
   logic [NUM_W-1:0]        p_num_ff, p_den_ff;
   div_side_type            p_side_ff;

   logic                    dn_valid;
   logic [Q2_W-1:0]         qn;
   div_side_type            ns_out;
   logic                    n_big;
   logic [N_MAG_W-1:0]      n_mag;
   logic signed [N_W-1:0]   n_in;
   logic                    c_v_ff;
   logic signed [N_W-1:0]   n_ff;
   side_type                c_side_ff;

   logic                    k_valid;
   logic [CH_W-1:0]         k_kelvin;
   logic                    k_sat;
   side_type                k_side;

   logic                    rsp_valid_ff;
   logic [CH_W-1:0]         kelvin_ff, lux_ff;
   logic [1:0]              status_ff, status_in;
   logic                    degen_beat;

   // whole pipeline holds while a result sits unaccepted
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   rgbcct_mat u_mat (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (m_valid),
      .x_val     (m_x),
      .y_val     (m_y),
      .s_val     (m_s),
      .lux       (m_lux),
      .lux_sat   (m_lux_sat)
   );

   always_comb begin
      x_abs = m_x[XYZ_W-1] ? -m_x : m_x;
      y_abs = m_y[XYZ_W-1] ? -m_y : m_y;
      s_abs = m_s[XYZ_W-1] ? -m_s : m_s;
      xs_in.neg          = m_x[XYZ_W-1] ^ m_s[XYZ_W-1];
      xs_in.side.degen   = (m_s == '0);
      xs_in.side.lux_sat = m_lux_sat;
      xs_in.side.lux     = m_lux;
      ys_in              = m_y[XYZ_W-1] ^ m_s[XYZ_W-1];
   end

   rgbcct_div #(
      .DVD_W  (Q1_W),
      .DVS_W  (MAG_W),
      .SIDE_W ($bits(div_side_type))
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m_valid),
      .dividend  ({x_abs[MAG_W-1:0], FRAC_W'(0)}),
      .divisor   (s_abs[MAG_W-1:0]),
      .side_in   (xs_in),
      .out_valid (dx_valid),
      .quotient  (qx),
      .side_out  (xs_out)
   );

   rgbcct_div #(
      .DVD_W  (Q1_W),
      .DVS_W  (MAG_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m_valid),
      .dividend  ({y_abs[MAG_W-1:0], FRAC_W'(0)}),
      .divisor   (s_abs[MAG_W-1:0]),
      .side_in   (ys_in),
      .out_valid (dy_valid),
      .quotient  (qy),
      .side_out  (ys_out)
   );

   // chromaticity offsets and their magnitudes for the n division
   always_comb begin
      xc      = xs_out.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      yc      = ys_out ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      num     = (NUM_W+1)'(xc) - X0_Q20;
      den     = Y0_Q20 - (NUM_W+1)'(yc);
      num_abs = num[NUM_W] ? -num : num;
      den_abs = den[NUM_W] ? -den : den;
      p_side_in       = xs_out.side;
      p_side_in.degen = xs_out.side.degen || (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (advance) begin
         p_v_ff <= dx_valid && dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_num_ff       <= num_abs[NUM_W-1:0];
         p_den_ff       <= den_abs[NUM_W-1:0];
         p_side_ff.neg  <= num[NUM_W] ^ den[NUM_W];
         p_side_ff.side <= p_side_in;
      end
   end

   rgbcct_div #(
      .DVD_W  (Q2_W),
      .DVS_W  (NUM_W),
      .SIDE_W ($bits(div_side_type))
   ) u_div_n (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p_v_ff),
      .dividend  ({p_num_ff, FRAC_W'(0)}),
      .divisor   (p_den_ff),
      .side_in   (p_side_ff),
      .out_valid (dn_valid),
      .quotient  (qn),
      .side_out  (ns_out)
   );

   // clamp n to +-16.0
   always_comb begin
      n_big = |qn[Q2_W-1:N_MAG_W-1];
      n_mag = n_big ? N_LIMIT : {1'b0, qn[N_MAG_W-2:0]};
      n_in  = ns_out.neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (advance) begin
         c_v_ff <= dn_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff      <= n_in;
         c_side_ff <= ns_out.side;
      end
   end

   rgbcct_cubic u_cubic (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (c_v_ff),
      .n          (n_ff),
      .side_in    (c_side_ff),
      .out_valid  (k_valid),
      .kelvin     (k_kelvin),
      .kelvin_sat (k_sat),
      .side_out   (k_side)
   );

   always_comb begin
      if (k_side.degen) begin
         status_in = STATUS_DEGEN;
      end else if (k_sat || k_side.lux_sat) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= k_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kelvin_ff <= k_side.degen ? '0 : k_kelvin;
         lux_ff    <= k_side.lux;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kelvin      = kelvin_ff;
   assign rsp_illuminance = lux_ff;
   assign rsp_status      = status_ff;

   assign degen_beat = rsp_valid && (rsp_status == STATUS_DEGEN);

   `RGBCCT_ASSERT(a_degen_kelvin, degen_beat |-> rsp_kelvin == '0, "kelvin set on degenerate beat")
   `RGBCCT_ASSERT(a_stall_back, rsp_valid && rsp_stall |-> req_stall, "output stall not held back")
   `RGBCCT_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "result valid right after reset")

endmodule

>>> bench/testbench.sv
// self-checking bench for the color temperature / lux block
`timescale 1ns / 1ps
module testbench
   import rgbcct_pkg::*;
();

   localparam int LATENCY   = 145;
   localparam int N_RANDOM  = 1750;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic [15:0] kelvin;
      logic [15:0] illuminance;
      logic [1:0]  status;
   } cct_result_type;

   typedef struct packed {
      logic [15:0]    red;
      logic [15:0]    green;
      logic [15:0]    blue;
      logic           has_fixed;
      cct_result_type fixed;
   } sample_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_red;
   logic [15:0] req_green;
   logic [15:0] req_blue;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_kelvin;
   logic [15:0] rsp_illuminance;
   logic [1:0]  rsp_status;

   cct_result_type pending_results[$];
   int             error_count = 0;
   int             cycle_count;
   bit             quiet_stretch;
   bit             long_hold;

   rgb_color_temperature_lux_top i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint shift_toward_zero(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> sh;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp16(longint v, ref bit sat);
      if (v < 0) begin
         sat = 1'b1;
         return 0;
      end
      if (v > 65535) begin
         sat = 1'b1;
         return 65535;
      end
      return v;
   endfunction

   // signed Q.20 quotient, magnitude clamped to 16.0
   function automatic longint ratio_q20(longint a, longint b);
      longint ua, ub, q, r, frac, mag;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (q >= 16) begin
         mag = 16 * 1048576;
      end else begin
         frac = 0;
         for (int i = 0; i < 20; i++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= ub) begin
               r -= ub;
               frac |= 1;
            end
         end
         mag = q * 1048576 + frac;
      end
      return neg ? -mag : mag;
   endfunction

   function automatic cct_result_type color_temp_of(logic [15:0] r, logic [15:0] g,
                                                   logic [15:0] b);
      cct_result_type res;
      longint cx, cy, cz, s, xc, yc, den, n, n2, n3, cct;
      bit sat;
      sat = 1'b0;
      cx = -64'sd9360 * r + 64'sd101531 * g - 64'sd62679 * b;
      cy = -64'sd21277 * r + 64'sd103440 * g - 64'sd47966 * b;
      cz = -64'sd44697 * r + 64'sd50511 * g + 64'sd36918 * b;
      res.illuminance = 16'(clamp16(shift_toward_zero(cy, 16), sat));
      res.kelvin = '0;
      res.status = STATUS_OK;
      s = cx + cy + cz;
      if (s == 0) begin
         res.status = STATUS_DEGEN;
      end else begin
         xc = (cx * 1048576) / s;
         yc = (cy * 1048576) / s;
         den = 194825 - yc;
         if (den == 0) begin
            res.status = STATUS_DEGEN;
         end else begin
            n = ratio_q20(xc - 348127, den);
            n2 = shift_toward_zero(n * n, 20);
            n3 = shift_toward_zero(n2 * n, 20);
            cct = 449 * n3 + 3525 * n2 + shift_toward_zero(64'sd7154748621 * n, 20)
                  + 64'sd5788485550;
            res.kelvin = 16'(clamp16(shift_toward_zero(cct, 20), sat));
         end
      end
      if (res.status == STATUS_OK && sat) res.status = STATUS_SAT;
      return res;
   endfunction

   // directed rows; fixed results only where obvious
   sample_row_type directed_rows[$] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, STATUS_DEGEN}},
      '{16'hffff, 16'h0000, 16'h0000, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0000, 16'hffff, 16'h0000, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0000, 16'h0000, 16'hffff, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'hffff, 16'hffff, 16'hffff, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'hffff, 16'hffff, 16'h0000, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0000, 16'hffff, 16'hffff, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'hffff, 16'h0000, 16'hffff, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0001, 16'h0001, 16'h0001, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0100, 16'h0100, 16'h0100, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h1000, 16'h2000, 16'h0800, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h2000, 16'h1000, 16'h0400, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0400, 16'h1000, 16'h2000, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h5555, 16'haaaa, 16'h5555, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'haaaa, 16'h5555, 16'haaaa, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0001, 16'h0000, 16'h0000, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h0000, 16'h0000, 16'h0001, 1'b0, '{16'd0, 16'd0, STATUS_OK}},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '{16'd0, 16'd0, STATUS_OK}}
   };

   // valid stays up after the beat so back to back beats need no gap
   task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              bit no_gaps);
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // expectations are queued at the accept edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_results.push_back(color_temp_of(req_red, req_green, req_blue));
   end

   // directed rows with fixed results are also checked against the predictor
   initial begin
      foreach (directed_rows[i])
         if (directed_rows[i].has_fixed &&
             color_temp_of(directed_rows[i].red, directed_rows[i].green,
                           directed_rows[i].blue) != directed_rows[i].fixed) begin
            $display("%0t: table row %0d disagrees with predictor", $time, i);
            error_count++;
         end
   end

   always @(posedge clock) begin
      cct_result_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat k=%0d lux=%0d st=%0d", $time,
                     rsp_kelvin, rsp_illuminance, rsp_status);
            error_count++;
         end else begin
            exp_beat = pending_results.pop_front();
            if (rsp_kelvin !== exp_beat.kelvin) begin
               $display("%0t: kelvin expected %0d actual %0d", $time,
                        exp_beat.kelvin, rsp_kelvin);
               error_count++;
            end
            if (rsp_illuminance !== exp_beat.illuminance) begin
               $display("%0t: illuminance expected %0d actual %0d", $time,
                        exp_beat.illuminance, rsp_illuminance);
               error_count++;
            end
            if (rsp_status !== exp_beat.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_beat.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_stall <= !quiet_stretch && ($urandom_range(99) < 28);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_MAX) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      logic [15:0] r, g, b;
      cycle_count   = 0;
      quiet_stretch = 1'b0;
      long_hold     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].red, directed_rows[i].green,
                     directed_rows[i].blue, 1'b0);
      // sender waits for everything to come back
      drain_results();

      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == 300) long_hold = 1'b1;
         quiet_stretch = (k >= 700 && k < 1000);
         if (k == 1200) drain_results();
         case ($urandom_range(3))
            0: begin
               r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
            end
            1: begin
               // small counts, near dark
               r = 16'($urandom_range(40)); g = 16'($urandom_range(40));
               b = 16'($urandom_range(40));
            end
            2: begin
               // similar channels with jitter, near grey
               g = 16'($urandom_range(65535, 256));
               r = g + 16'($urandom_range(2000)) - 16'd1000;
               b = g + 16'($urandom_range(2000)) - 16'd1000;
            end
            default: begin
               r = $urandom_range(1) ? 16'hffff : 16'($urandom);
               g = $urandom_range(1) ? 16'h0000 : 16'($urandom);
               b = $urandom_range(1) ? 16'hffff : 16'($urandom_range(255));
            end
         endcase
         send_sample(r, g, b, quiet_stretch);
      end
      quiet_stretch = 1'b0;
      drain_results();
      repeat (LATENCY + 20) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

>>> rgb_color_temperature_lux_top.f
+incdir+sv
sv/rgbcct_pkg.sv
sv/rgbcct_div.sv
sv/rgbcct_mat.sv
sv/rgbcct_cubic.sv
sv/rgb_color_temperature_lux_top.sv
bench/testbench.sv
